// ===== rtl/pdu_pkg.sv =====
// shared types and constants for the pixel doubling upscaler
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package pdu_pkg;

   // image limits and derived widths
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int DIM_W      = 12;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int PIX_W      = 24;
   localparam int CSR_IDX_W  = 1;

   // item opcodes
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 1'b1;

   // pad byte count when the width is odd
   localparam logic [1:0] PAD_ODD  = 2'd2;
   localparam logic [1:0] PAD_NONE = 2'd0;

   typedef struct packed {
      logic       opcode;
      logic [7:0] in_blue;
      logic [7:0] in_green;
      logic [7:0] in_red;
   } req_type;

   typedef struct packed {
      logic [7:0] out_blue;
      logic [7:0] out_green;
      logic [7:0] out_red;
      logic       row_end;
      logic [1:0] pad_bytes;
      logic       image_end;
      logic       last;
   } rsp_type;

   // command passed from the front end to the output side
   typedef struct packed {
      logic             is_tick;
      logic [COL_W-1:0] addr;
      logic [PIX_W-1:0] pix;
      logic             row_end;
      logic [1:0]       pad;
      logic             image_end;
   } cmd_type;

   // queue status seen by its producer and consumer
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== rtl/pixel_doubling_upscaler_core.sv =====
// 2x nearest neighbour upscaler: each accepted pixel or replay tick gives two results.
// each result passes through the command queue and the command holding stage into the result register.
// an item holds the command stage until both of its results enter the single-beat result register.
// the front end takes an item each cycle until the 4-entry command queue fills.
// synchronous active-high reset clears counters, queue and valids; width/height reset to 1.
// line store contents are undefined after reset until a row is written.
`timescale 1ns / 1ps
`default_nettype none

module pixel_doubling_upscaler_core (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire pdu_pkg::req_type            req_payload,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output pdu_pkg::rsp_type                 rsp_payload,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [pdu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [pdu_pkg::DIM_W-1:0]        csr_data
);

   logic                       push_valid, pop;
   pdu_pkg::cmd_type           push_cmd, head_cmd;
   pdu_pkg::queue_status_type  q_status;

   assign csr_ready = 1'b1;
   assign req_stall = q_status.full;

   pdu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .csr_valid   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .push_valid  (push_valid),
      .push_cmd    (push_cmd)
   );

   pdu_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   pdu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_cmd    (head_cmd),
      .q_status    (q_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== rtl/pdu_front.sv =====
// front end: accepts items, holds configuration and row/column counters
// classifies each item into a store or replay command, or ignores it; uses pdu_pkg
`timescale 1ns / 1ps
`default_nettype none

module pdu_front (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   input  wire                                req_stall,
   input  wire pdu_pkg::req_type              req_payload,
   input  wire                                csr_valid,
   input  wire  [pdu_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [pdu_pkg::DIM_W-1:0]          csr_data,
   output logic                               push_valid,
   output pdu_pkg::cmd_type                   push_cmd
);

   logic [pdu_pkg::DIM_W-1:0] width_ff, height_ff;
   logic [pdu_pkg::COL_W-1:0] fill_column_ff, fill_column_in;
   logic [pdu_pkg::COL_W-1:0] replay_column_ff, replay_column_in;
   logic [pdu_pkg::ROW_W-1:0] row_count_ff, row_count_in;
   logic                      replay_pending_ff, replay_pending_in;

   logic [pdu_pkg::DIM_W-1:0] w_eff, h_eff;
   logic                      accept, is_pixel;
   logic                      fill_end, replay_end, last_row;

   // configuration writes, ready is always high
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= pdu_pkg::DIM_W'(1);
         height_ff <= pdu_pkg::DIM_W'(1);
      end else if (csr_valid) begin
         if (csr_index == pdu_pkg::CSR_WIDTH) width_ff <= csr_data;
         if (csr_index == pdu_pkg::CSR_HEIGHT) height_ff <= csr_data;
      end
   end

   // clamp dimensions into 1..max
   always_comb begin
      if (width_ff == '0) w_eff = pdu_pkg::DIM_W'(1);
      else if (width_ff > pdu_pkg::DIM_W'(pdu_pkg::MAX_WIDTH))
         w_eff = pdu_pkg::DIM_W'(pdu_pkg::MAX_WIDTH);
      else w_eff = width_ff;
      if (height_ff == '0) h_eff = pdu_pkg::DIM_W'(1);
      else if (height_ff > pdu_pkg::DIM_W'(pdu_pkg::MAX_HEIGHT))
         h_eff = pdu_pkg::DIM_W'(pdu_pkg::MAX_HEIGHT);
      else h_eff = height_ff;
   end

   assign accept   = req_valid && !req_stall;
   assign is_pixel = (req_payload.opcode == pdu_pkg::OP_PIXEL);

   assign fill_end   = (pdu_pkg::DIM_W'(fill_column_ff) + pdu_pkg::DIM_W'(1)) >= w_eff;
   assign replay_end = (pdu_pkg::DIM_W'(replay_column_ff) + pdu_pkg::DIM_W'(1)) >= w_eff;
   assign last_row   = (pdu_pkg::DIM_W'(row_count_ff) + pdu_pkg::DIM_W'(1)) >= h_eff;

   // classify and update counters; ignored items leave state alone
   always_comb begin
      fill_column_in    = fill_column_ff;
      replay_column_in  = replay_column_ff;
      row_count_in      = row_count_ff;
      replay_pending_in = replay_pending_ff;
      push_valid        = 1'b0;
      push_cmd.is_tick  = !is_pixel;
      push_cmd.pix      = {req_payload.in_red, req_payload.in_green, req_payload.in_blue};
      push_cmd.pad      = w_eff[0] ? pdu_pkg::PAD_ODD : pdu_pkg::PAD_NONE;
      push_cmd.addr     = is_pixel ? fill_column_ff : replay_column_ff;
      push_cmd.row_end  = is_pixel ? fill_end : replay_end;
      push_cmd.image_end = !is_pixel && replay_end && last_row;
      if (accept && is_pixel && !replay_pending_ff) begin
         push_valid = 1'b1;
         if (fill_end) begin
            fill_column_in    = '0;
            replay_column_in  = '0;
            replay_pending_in = 1'b1;
         end else begin
            fill_column_in = fill_column_ff + pdu_pkg::COL_W'(1);
         end
      end else if (accept && !is_pixel && replay_pending_ff) begin
         push_valid = 1'b1;
         if (replay_end) begin
            replay_column_in  = '0;
            replay_pending_in = 1'b0;
            row_count_in      = last_row ? '0 : row_count_ff + pdu_pkg::ROW_W'(1);
         end else begin
            replay_column_in = replay_column_ff + pdu_pkg::COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_column_ff    <= '0;
         replay_column_ff  <= '0;
         row_count_ff      <= '0;
         replay_pending_ff <= 1'b0;
      end else begin
         fill_column_ff    <= fill_column_in;
         replay_column_ff  <= replay_column_in;
         row_count_ff      <= row_count_in;
         replay_pending_ff <= replay_pending_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/pdu_cmd_queue.sv =====
// four entry command queue between front end and output side
// register based fifo of pdu_pkg::cmd_type entries
`timescale 1ns / 1ps
`default_nettype none

module pdu_cmd_queue (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          push,
   input  wire pdu_pkg::cmd_type        push_cmd,
   input  wire                          pop,
   output pdu_pkg::cmd_type             head_cmd,
   output pdu_pkg::queue_status_type    status
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   pdu_pkg::cmd_type   entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]     count_ff, count_in;
   logic               do_push, do_pop;

   assign status.full  = (count_ff == (PTR_W+1)'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_cmd     = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + (PTR_W+1)'(1);
      else if (do_pop && !do_push) count_in = count_ff - (PTR_W+1)'(1);
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

`default_nettype wire

// ===== rtl/pdu_back.sv =====
// output side: line store, command execution and two-beat emitter
// consumes pdu_pkg::cmd_type from the queue, drives the result register
`timescale 1ns / 1ps
`default_nettype none

module pdu_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire pdu_pkg::cmd_type        head_cmd,
   input  wire pdu_pkg::queue_status_type q_status,
   output logic                         pop,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output pdu_pkg::rsp_type             rsp_payload
);

   logic [pdu_pkg::PIX_W-1:0] line_store [pdu_pkg::MAX_WIDTH];
   logic [pdu_pkg::PIX_W-1:0] rdata_ff;

   pdu_pkg::cmd_type          b_cmd_ff;
   logic                      b_valid_ff, b_valid_in;
   logic                      beat_ff;
   logic                      out_load, b_done;
   logic [pdu_pkg::PIX_W-1:0] b_pix;
   logic                      rsp_valid_ff;
   pdu_pkg::rsp_type          rsp_ff;
   logic                      mark;

   assign out_load = b_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign b_done   = out_load && beat_ff;
   assign pop      = !q_status.empty && (!b_valid_ff || b_done);

   // line store: pixel commands write, tick commands read
   always_ff @(posedge clock) begin
      if (pop) begin
         if (head_cmd.is_tick) rdata_ff <= line_store[head_cmd.addr];
         else line_store[head_cmd.addr] <= head_cmd.pix;
      end
   end

   // command holding stage
   always_comb begin
      b_valid_in = b_valid_ff;
      if (pop) b_valid_in = 1'b1;
      else if (b_done) b_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         beat_ff    <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
         if (out_load) beat_ff <= !beat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) b_cmd_ff <= head_cmd;
   end

   assign b_pix = b_cmd_ff.is_tick ? rdata_ff : b_cmd_ff.pix;
   assign mark  = b_cmd_ff.row_end && beat_ff;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff.out_blue  <= b_pix[7:0];
         rsp_ff.out_green <= b_pix[15:8];
         rsp_ff.out_red   <= b_pix[23:16];
         rsp_ff.row_end   <= mark;
         rsp_ff.pad_bytes <= mark ? b_cmd_ff.pad : pdu_pkg::PAD_NONE;
         rsp_ff.image_end <= b_cmd_ff.image_end && beat_ff;
         rsp_ff.last      <= beat_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// self-checking bench for pixel_doubling_upscaler_core: directed table, then random rows
// every replayed pixel is predicted from a private copy of the stored row; needs rtl/pdu_pkg.sv
`timescale 1ns / 1ps

module tb_top;
   import pdu_pkg::*;

   // pixel pair predicted for one input transaction
   typedef struct packed {
      logic        produced;
      logic [23:0] pix;        // {red, green, blue}
      logic        row_end;
      logic [1:0]  pad;
      logic        image_end;
   } pixel_pair_type;

   // one line of the directed table: a register write or an item
   typedef struct packed {
      logic                 is_csr;
      logic [CSR_IDX_W-1:0] csr_idx;
      logic [DIM_W-1:0]     csr_value;
      req_type              item;
      logic                 typed;
      pixel_pair_type       pair;
   } directed_row_type;

   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int PRINT_LIMIT   = 100;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_valid   = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [DIM_W-1:0]     csr_data    = '0;

   // predicted block state
   logic [23:0]      row_copy [MAX_WIDTH];
   logic [COL_W-1:0] fill_col;
   logic [COL_W-1:0] replay_col;
   int unsigned      row_idx;
   int unsigned      store_extent;
   logic             replay_waiting;
   logic             row_closed;
   logic [DIM_W-1:0] width_reg;
   logic [DIM_W-1:0] height_reg;

   rsp_type          expected_pixels [$];
   directed_row_type directed_rows [$];

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int mismatch_count = 0;
   int items_accepted = 0;
   int results_checked = 0;
   int reg_writes = 0;
   int rows_replayed = 0;
   int images_closed = 0;

   pixel_doubling_upscaler_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // 100 MHz clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one line per mismatch, printing capped so a dead block cannot flood the log
   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT) $display("%0t mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // register value as the block uses it: zero acts as one, large values saturate
   function automatic int unsigned dim_limit(input logic [DIM_W-1:0] value,
                                             input int unsigned ceiling);
      if (value == 0) return 1;
      if (value > ceiling) return ceiling;
      return value;
   endfunction

   // pixel pair for one item, advancing the predicted state
   function automatic pixel_pair_type predict_upscale(input req_type it);
      pixel_pair_type p;
      int unsigned    w;
      int unsigned    h;
      w = dim_limit(width_reg, MAX_WIDTH);
      h = dim_limit(height_reg, MAX_HEIGHT);
      p = '0;
      p.pad = w[0] ? PAD_ODD : PAD_NONE;
      row_closed = 1'b0;
      if (it.opcode == OP_PIXEL && !replay_waiting) begin
         p.produced = 1'b1;
         p.pix = {it.in_red, it.in_green, it.in_blue};
         row_copy[fill_col] = p.pix;
         if (fill_col + 1 > store_extent) store_extent = fill_col + 1;
         p.row_end = (fill_col + 1 >= w);
         if (p.row_end) begin
            fill_col = '0;
            replay_col = '0;
            replay_waiting = 1'b1;
         end else begin
            fill_col++;
         end
      end else if (it.opcode == OP_TICK && replay_waiting) begin
         p.produced = 1'b1;
         p.pix = row_copy[replay_col];
         p.row_end = (replay_col + 1 >= w);
         if (p.row_end) begin
            replay_col = '0;
            replay_waiting = 1'b0;
            row_closed = 1'b1;
            rows_replayed++;
            if (row_idx + 1 >= h) begin
               p.image_end = 1'b1;
               row_idx = 0;
               images_closed++;
            end else begin
               row_idx++;
            end
         end else begin
            replay_col++;
         end
      end
      return p;
   endfunction

   // queue the two results of a pair; flags sit on the second one only
   task automatic push_pair(input pixel_pair_type p);
      rsp_type r;
      if (p.produced) begin
         r = '0;
         {r.out_red, r.out_green, r.out_blue} = p.pix;
         expected_pixels.push_back(r);
         r.row_end   = p.row_end;
         r.pad_bytes = p.row_end ? p.pad : PAD_NONE;
         r.image_end = p.image_end;
         r.last      = 1'b1;
         expected_pixels.push_back(r);
      end
   endtask

   // drive one transaction and queue what it should produce
   task automatic send_item(input req_type it, input logic typed,
                            input pixel_pair_type typed_pair, output logic produced);
      pixel_pair_type p;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= it;
      do @(posedge clock); while (req_stall !== 1'b0);
      p = predict_upscale(it);
      if (typed) p = typed_pair;
      push_pair(p);
      produced = p.produced;
      items_accepted++;
   endtask

   // register write, only once the block has gone quiet
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      // ignored items are dropped by the front end and never enter the command queue
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      if (idx == CSR_WIDTH) width_reg = value;
      else height_reg = value;
      reg_writes++;
   endtask

   // next item of a well-formed stream, with an occasional out-of-turn opcode
   function automatic req_type next_upscale_item(input logic noisy);
      req_type     it;
      logic [23:0] color;
      color = 24'($urandom);
      it.opcode = replay_waiting ? OP_TICK : OP_PIXEL;
      if (noisy && $urandom_range(99) < 8) it.opcode = ~it.opcode;
      {it.in_red, it.in_green, it.in_blue} = color;
      return it;
   endfunction

   // run clean items until a replayed row closes
   task automatic finish_row();
      logic produced;
      do send_item(next_upscale_item(1'b0), 1'b0, '0, produced);
      while (!row_closed);
   endtask

   function automatic directed_row_type item_row(input logic op, input logic [23:0] color);
      directed_row_type row;
      row = '0;
      row.item.opcode = op;
      {row.item.in_red, row.item.in_green, row.item.in_blue} = color;
      return row;
   endfunction

   function automatic directed_row_type typed_row(input logic op, input logic [23:0] color,
                                                  input logic produced, input logic [23:0] pix,
                                                  input logic rend, input logic [1:0] pad,
                                                  input logic iend);
      directed_row_type row;
      row = item_row(op, color);
      row.typed = 1'b1;
      row.pair  = '{produced: produced, pix: pix, row_end: rend, pad: pad, image_end: iend};
      return row;
   endfunction

   function automatic directed_row_type csr_row(input logic [CSR_IDX_W-1:0] idx,
                                                input logic [DIM_W-1:0] value);
      directed_row_type row;
      row = '0;
      row.is_csr    = 1'b1;
      row.csr_idx   = idx;
      row.csr_value = value;
      return row;
   endfunction

   // extremes, both opcodes, ignored items and out-of-range registers
   task automatic load_directed();
      // reset settings: width 1, height 1
      directed_rows.push_back(typed_row(OP_TICK, 24'h000000, 1'b0, 24'h0, 1'b0, PAD_NONE,
                                        1'b0));
      directed_rows.push_back(typed_row(OP_PIXEL, 24'hffffff, 1'b1, 24'hffffff, 1'b1, PAD_ODD,
                                        1'b0));
      // pixel while the row still waits for replay
      directed_rows.push_back(typed_row(OP_PIXEL, 24'h000000, 1'b0, 24'h0, 1'b0, PAD_NONE,
                                        1'b0));
      directed_rows.push_back(typed_row(OP_TICK, 24'h000000, 1'b1, 24'hffffff, 1'b1, PAD_ODD,
                                        1'b1));
      // zero width acts as one
      directed_rows.push_back(csr_row(CSR_WIDTH, 12'd0));
      directed_rows.push_back(typed_row(OP_PIXEL, 24'hc35aa5, 1'b1, 24'hc35aa5, 1'b1, PAD_ODD,
                                        1'b0));
      directed_rows.push_back(typed_row(OP_TICK, 24'hffffff, 1'b1, 24'hc35aa5, 1'b1, PAD_ODD,
                                        1'b1));
      // odd width, one row of a two-row image
      directed_rows.push_back(csr_row(CSR_HEIGHT, 12'd2));
      directed_rows.push_back(csr_row(CSR_WIDTH, 12'd3));
      directed_rows.push_back(item_row(OP_PIXEL, 24'h000000));
      directed_rows.push_back(item_row(OP_PIXEL, 24'h3ca55a));
      directed_rows.push_back(item_row(OP_PIXEL, 24'hffffff));
      directed_rows.push_back(typed_row(OP_PIXEL, 24'h123456, 1'b0, 24'h0, 1'b0, PAD_NONE,
                                        1'b0));
      repeat (3) directed_rows.push_back(item_row(OP_TICK, 24'h000000));
      // tick with no row waiting for replay
      directed_rows.push_back(typed_row(OP_TICK, 24'hffffff, 1'b0, 24'h0, 1'b0, PAD_NONE,
                                        1'b0));
      // even width, height above the maximum
      directed_rows.push_back(csr_row(CSR_WIDTH, 12'd4));
      directed_rows.push_back(csr_row(CSR_HEIGHT, 12'hfff));
      directed_rows.push_back(item_row(OP_PIXEL, 24'hffffff));
      directed_rows.push_back(item_row(OP_PIXEL, 24'h000000));
      directed_rows.push_back(item_row(OP_PIXEL, 24'h5aa5c3));
      directed_rows.push_back(item_row(OP_PIXEL, 24'ha55a3c));
      repeat (4) directed_rows.push_back(item_row(OP_TICK, 24'h000000));
      // height shrunk below the row count closes the image on the next row
      directed_rows.push_back(csr_row(CSR_HEIGHT, 12'd0));
      directed_rows.push_back(csr_row(CSR_WIDTH, 12'd1));
      directed_rows.push_back(item_row(OP_PIXEL, 24'h8001fe));
      directed_rows.push_back(item_row(OP_TICK, 24'h000000));
   endtask

   // random segments: new settings at quiet points, then a stream of rows
   task automatic run_phase(input int gap_pct, input int stall_pct, input int budget,
                            input logic widest_row);
      int               accepted_here;
      int               target;
      int               done;
      logic             produced;
      logic [DIM_W-1:0] value;
      req_idle_pct  = gap_pct;
      rsp_idle_pct  = stall_pct;
      accepted_here = 0;
      if (widest_row) begin
         // one full row at the widest setting, given as an out-of-range value
         write_reg(CSR_WIDTH, 12'd1);
         finish_row();
         write_reg(CSR_WIDTH, 12'hfff);
         finish_row();
      end
      while (accepted_here < budget) begin
         // a pending replay must never run past what the row store holds
         if ($urandom_range(3) != 0) begin
            case ($urandom_range(9))
               0:       value = '0;
               1:       value = DIM_W'($urandom_range(MAX_WIDTH, 4095));
               default: value = DIM_W'($urandom_range(1, 9));
            endcase
            if (replay_waiting && dim_limit(value, MAX_WIDTH) > store_extent)
               value = DIM_W'(store_extent);
            write_reg(CSR_WIDTH, value);
         end
         if ($urandom_range(3) != 0) begin
            case ($urandom_range(7))
               0:       value = '0;
               1:       value = DIM_W'($urandom_range(MAX_HEIGHT, 4095));
               default: value = DIM_W'($urandom_range(1, 4));
            endcase
            write_reg(CSR_HEIGHT, value);
         end
         target = $urandom_range(4, 40);
         done = 0;
         while (done < target) begin
            send_item(next_upscale_item(1'b1), 1'b0, '0, produced);
            if (produced) done++;
         end
         accepted_here += done;
      end
   endtask

   // result side: random stall, field-by-field check against the oldest expectation
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("result %h with nothing expected", rsp_payload));
         end else begin
            want = expected_pixels.pop_front();
            results_checked++;
            if (rsp_payload.out_blue !== want.out_blue)
               report_mismatch($sformatf("out_blue %h, expected %h",
                                         rsp_payload.out_blue, want.out_blue));
            if (rsp_payload.out_green !== want.out_green)
               report_mismatch($sformatf("out_green %h, expected %h",
                                         rsp_payload.out_green, want.out_green));
            if (rsp_payload.out_red !== want.out_red)
               report_mismatch($sformatf("out_red %h, expected %h",
                                         rsp_payload.out_red, want.out_red));
            if (rsp_payload.row_end !== want.row_end)
               report_mismatch($sformatf("row_end %b, expected %b",
                                         rsp_payload.row_end, want.row_end));
            if (rsp_payload.pad_bytes !== want.pad_bytes)
               report_mismatch($sformatf("pad_bytes %0d, expected %0d",
                                         rsp_payload.pad_bytes, want.pad_bytes));
            if (rsp_payload.image_end !== want.image_end)
               report_mismatch($sformatf("image_end %b, expected %b",
                                         rsp_payload.image_end, want.image_end));
            if (rsp_payload.last !== want.last)
               report_mismatch($sformatf("last %b, expected %b",
                                         rsp_payload.last, want.last));
         end
      end
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   // main sequence
   initial begin : stimulus
      directed_row_type row;
      logic             produced;
      width_reg      = 12'd1;
      height_reg     = 12'd1;
      fill_col       = '0;
      replay_col     = '0;
      row_idx        = 0;
      store_extent   = 0;
      replay_waiting = 1'b0;
      row_closed     = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      load_directed();
      req_idle_pct = 20;
      rsp_idle_pct = 46;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_csr) write_reg(row.csr_idx, row.csr_value);
         else send_item(row.item, row.typed, row.pair, produced);
      end

      run_phase(20, 46, 120, 1'b0);
      run_phase(46, 20, 120, 1'b0);
      run_phase(0, 0, 120, 1'b0);
      req_valid <= 1'b0;

      // drain, then give stray results time to show up
      for (int n = 0; n < DRAIN_LIMIT && expected_pixels.size() != 0; n++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_pixels.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));

      $display("covered %0d transactions in, %0d results checked, %0d register writes",
               items_accepted, results_checked, reg_writes);
      $display("covered %0d replayed rows and %0d closed images", rows_replayed, images_closed);
      if (mismatch_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   // hard stop if the block hangs
   initial begin : watchdog
      #(10_000_000);
      $display("timeout: block stopped making progress");
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
